// ===== design/bmt_pkg.sv =====
// Package: constants, state codes and the Barrett reciprocal for the binomial table.
`timescale 1ns / 1ps
`default_nettype none
package bmt_pkg;
  localparam int MaxN = 4096;
  localparam int AddrW = 13;
  localparam int ValW = 30;
  localparam logic [29:0] Prime = 30'd998244353;
  localparam logic [29:0] PrimeMinus2 = 30'd998244351;
  localparam logic [AddrW-1:0] LimitReset = 13'd4096;
  localparam logic [1:0] RegLimit = 2'd0;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_FACT   = 11'b00000000010,
    ST_FWAIT  = 11'b00000000100,
    ST_EXP    = 11'b00000001000,
    ST_EWAIT  = 11'b00000010000,
    ST_INV    = 11'b00000100000,
    ST_IWAIT  = 11'b00001000000,
    ST_QREAD  = 11'b00010000000,
    ST_QMUL1  = 11'b00100000000,
    ST_QMUL2  = 11'b01000000000,
    ST_QDONE  = 11'b10000000000
  } state_t;

  // Barrett reciprocal for a 60-bit product: floor(2^60 / p), fits in 31 bits.
  localparam logic [30:0] Mu = 31'((64'd1 << 60) / 64'(Prime));
endpackage
`default_nettype wire

// ===== design/bmt_mulmod.sv =====
// Module: pipelined modular multiplier, a*b mod 998244353 in four registered stages.
`timescale 1ns / 1ps
`default_nettype none
module bmt_mulmod (
  input  wire logic                 clk,
  input  wire logic [29:0]          a,
  input  wire logic [29:0]          b,
  output logic      [29:0]          y
);
  import bmt_pkg::*;

  logic [59:0] prod;
  logic [61:0] qhat;
  logic [31:0] x_lo;
  logic [31:0] x_lo_d;
  logic [31:0] qp_lo;
  logic [31:0] s1;

  // stage 1: raw product
  always_ff @(posedge clk) begin
    prod <= 60'(a) * 60'(b);
  end

  // stage 2: quotient estimate from the top bits times the reciprocal
  always_ff @(posedge clk) begin
    qhat <= 62'(prod[59:29]) * 62'(Mu);
    x_lo <= prod[31:0];
  end

  // stage 3: quotient times prime, low 32 bits are enough
  always_ff @(posedge clk) begin
    qp_lo <= 32'(qhat[61:31] * Prime);
    x_lo_d <= x_lo;
  end

  // stage 4: remainder, below 3p since the estimate is short by at most two
  always_ff @(posedge clk) begin
    s1 <= x_lo_d - qp_lo;
  end

  always_comb begin
    logic [31:0] t;
    t = s1;
    if (t >= {2'b00, Prime} + {2'b00, Prime}) t = t - {2'b00, Prime} - {2'b00, Prime};
    if (t >= {2'b00, Prime}) t = t - {2'b00, Prime};
    y = t[29:0];
  end
endmodule
`default_nettype wire

// ===== design/binomial_mod_prime_table.sv =====
// Top level: binomial coefficient mod 998244353 with factorial tables in memory.
// A query with valid tables passes ST_QREAD, ST_QMUL1, ST_QMUL2 and ST_QDONE, then raises valid.
// After a limit write (and after reset) the first query rebuilds both tables first;
//   this grows with the limit, as each table entry waits on the 4-stage multiplier.
// A new query is taken only once busy drops; results cannot be stalled by the receiver.
// Reset clears control state and marks tables stale; memories are left undefined.
`timescale 1ns / 1ps
`default_nettype none
module binomial_mod_prime_table (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [12:0]          n_top,
  input  wire logic signed [13:0]   k_pick,
  output logic                      valid,
  output logic [29:0]               binom_value,
  output logic                      out_of_range,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import bmt_pkg::*;

  logic [ValW-1:0] fact_mem [0:MaxN];
  logic [ValW-1:0] ifact_mem [0:MaxN];

  state_t state;
  logic [12:0] table_limit;
  logic tables_valid;
  logic [12:0] lim, idx, n_q;
  logic [13:0] k_q;
  logic [29:0] exp_left;
  logic [29:0] acc, sq, prev;
  logic [2:0] wait_cnt;
  logic [29:0] ma, mb, my;
  logic [29:0] rd_fact, rd_ik, rd_ink;
  logic [29:0] p1;
  logic [4:0] exp_bits;
  logic phase;

  bmt_mulmod u_mul (.clk(clk), .a(ma), .b(mb), .y(my));

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegLimit[0]) ? {19'd0, table_limit} : 32'd0;
  assign busy = (state != ST_IDLE);
  assign lim = (table_limit > 13'(MaxN)) ? 13'(MaxN) : table_limit;

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_limit <= LimitReset;
    end else if (psel && penable && pwrite && paddr[2] == RegLimit[0]) begin
      table_limit <= pwdata[12:0];
    end
  end

  // synchronous memory reads
  logic [12:0] ra_f, ra_a, ra_b;
  always_ff @(posedge clk) begin
    rd_fact <= fact_mem[ra_f];
    rd_ik <= ifact_mem[ra_a];
    rd_ink <= ifact_mem[ra_b];
  end

  logic k_ok;
  assign k_ok = !k_q[13] && (k_q[12:0] <= n_q);
  always_comb begin
    ra_f = n_q;
    ra_a = k_q[12:0];
    ra_b = n_q - k_q[12:0];
  end

  // multiplier operand select
  always_comb begin
    ma = prev;
    mb = {17'd0, idx};
    case (state)
      ST_EXP, ST_EWAIT: begin
        ma = phase ? sq : acc;
        mb = sq;
      end
      ST_QMUL1: begin
        ma = rd_fact;
        mb = rd_ik;
      end
      ST_QMUL2: begin
        ma = p1;
        mb = rd_ink;
      end
      default: ;
    endcase
  end

  // control sequencer: table rebuild and query
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tables_valid <= 1'b0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      if (psel && penable && pwrite && paddr[2] == RegLimit[0]) tables_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            n_q <= n_top;
            k_q <= k_pick;
            if (!tables_valid) begin
              fact_mem[0] <= 30'd1;
              prev <= 30'd1;
              idx <= 13'd1;
              state <= (lim == 13'd0) ? ST_EXP : ST_FACT;
              acc <= 30'd1;
              sq <= 30'd1;
              exp_left <= PrimeMinus2;
              exp_bits <= 5'd0;
              phase <= 1'b0;
              wait_cnt <= 3'd0;
            end else begin
              state <= ST_QREAD;
              wait_cnt <= 3'd0;
            end
          end
        end
        // fact[idx] = fact[idx-1]*idx, waiting for the multiplier result
        ST_FACT: begin
          wait_cnt <= 3'd0;
          state <= ST_FWAIT;
        end
        ST_FWAIT: begin
          wait_cnt <= wait_cnt + 3'd1;
          if (wait_cnt == 3'd3) begin
            fact_mem[idx] <= my;
            prev <= my;
            if (idx == lim) begin
              sq <= my;
              state <= ST_EXP;
            end else begin
              idx <= idx + 13'd1;
              state <= ST_FACT;
            end
          end
        end
        // square and multiply: phase 0 updates acc, phase 1 squares
        ST_EXP: begin
          if (lim == 13'd0 && exp_bits == 5'd0 && !phase && acc == 30'd1 && sq == 30'd1) begin
            sq <= 30'd1;
          end
          wait_cnt <= 3'd0;
          state <= ST_EWAIT;
        end
        ST_EWAIT: begin
          wait_cnt <= wait_cnt + 3'd1;
          if (wait_cnt == 3'd3) begin
            if (!phase) begin
              if (exp_left[0]) acc <= my;
              phase <= 1'b1;
              state <= ST_EXP;
            end else begin
              sq <= my;
              phase <= 1'b0;
              exp_left <= exp_left >> 1;
              exp_bits <= exp_bits + 5'd1;
              if (exp_bits == 5'd29) begin
                ifact_mem[lim] <= acc;
                prev <= acc;
                idx <= lim;
                state <= (lim == 13'd0) ? ST_QREAD : ST_INV;
                if (lim == 13'd0) tables_valid <= 1'b1;
              end else begin
                state <= ST_EXP;
              end
            end
          end
        end
        // ifact[idx-1] = ifact[idx]*idx
        ST_INV: begin
          wait_cnt <= 3'd0;
          state <= ST_IWAIT;
        end
        ST_IWAIT: begin
          wait_cnt <= wait_cnt + 3'd1;
          if (wait_cnt == 3'd3) begin
            ifact_mem[idx - 13'd1] <= my;
            prev <= my;
            idx <= idx - 13'd1;
            if (idx == 13'd1) begin
              tables_valid <= 1'b1;
              state <= ST_QREAD;
            end else begin
              state <= ST_INV;
            end
          end
        end
        // query: read, then two chained multiplies
        ST_QREAD: begin
          wait_cnt <= 3'd0;
          state <= ST_QMUL1;
        end
        ST_QMUL1: begin
          wait_cnt <= wait_cnt + 3'd1;
          if (wait_cnt == 3'd4) begin
            p1 <= my;
            wait_cnt <= 3'd0;
            state <= ST_QMUL2;
          end
        end
        ST_QMUL2: begin
          wait_cnt <= wait_cnt + 3'd1;
          if (wait_cnt == 3'd4) state <= ST_QDONE;
        end
        ST_QDONE: begin
          valid <= 1'b1;
          out_of_range <= (n_q > lim);
          binom_value <= ((n_q <= lim) && k_ok) ? my : 30'd0;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
